>>> rtl/core/kpq_pkg.sv
// Package for the key press qualifier: widths, register map and the event word.
// Used by key_press_qualifier_unit; depends on nothing else.
package kpq_pkg;

    // Width of the press, repeat and click timers.
    localparam int TIMER_BITS = 16;
    // Width of the time thresholds held in the configuration registers.
    localparam int CFG_BITS = 16;
    // Width used when a timer is compared with a threshold.
    localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam int INTERVAL_BITS = 8;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int IN_WORD_BITS = 16;
    localparam int OUT_WORD_BITS = 8;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [CFG_BITS-1:0] cfg_time_t;
    typedef logic [INTERVAL_BITS-1:0] interval_t;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_DOWN_EN  = 3'd0,
        REG_UP_EN    = 3'd1,
        REG_DC_EN    = 3'd2,
        REG_REP_EN   = 3'd3,
        REG_DEBOUNCE = 3'd4,
        REG_LONG     = 3'd5,
        REG_PERIOD   = 3'd6,
        REG_WINDOW   = 3'd7
    } reg_index_t;

    localparam cfg_time_t DEBOUNCE_RESET = CFG_BITS'(20);
    localparam cfg_time_t LONG_RESET     = CFG_BITS'(400);
    localparam cfg_time_t PERIOD_RESET   = CFG_BITS'(80);
    localparam cfg_time_t WINDOW_RESET   = CFG_BITS'(200);

    // Result word; the last member sits in bit 0.
    typedef struct packed {
        logic beep_repeat;
        logic beep_press;
        logic repeat_event;
        logic double_click_event;
        logic key_up_event;
        logic key_down_event;
    } events_t;

    // Saturating timer add.
    function automatic timer_t sat_add(input timer_t a, input interval_t b);
        logic [TIMER_BITS:0] s;
        s = {1'b0, a} + (TIMER_BITS+1)'(b);
        return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/key_press_qualifier_unit.sv
// Key press qualifier: debounce, long press, auto-repeat and double click per scan tick.
// Depends on kpq_pkg; kpq_checker binds to it.
//
//  Channel   Direction  Word fields (lowest bit up)
//  s_axis    in         scan_interval[7:0], key_pressed[8], zero pad
//  m_axis    out        key_down, key_up, double_click, repeat, beep_press, beep_repeat, pad
//  apb       in         eight registers at byte addresses 0, 4, ... 28
//
// One word is taken every cycle; its result appears in the output register the next cycle.
// The only limit on rate is the output register: s_tready is low while a result waits
// with m_tready low. All state is updated by one pass of adders and compares.
// Reset clears all timers and flags and loads the register defaults.
module key_press_qualifier_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // scan_interval[7:0], key_pressed[8]
    input  logic [kpq_pkg::IN_WORD_BITS-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // down, up, double_click, repeat, beep_press, beep_repeat
    output logic [kpq_pkg::OUT_WORD_BITS-1:0] m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kpq_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [kpq_pkg::DATA_BITS-1:0]     pwdata,
    output logic [kpq_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready
);

    logic down_en_reg, up_en_reg, dc_en_reg, rep_en_reg;
    kpq_pkg::cfg_time_t debounce_reg, long_reg, period_reg, window_reg;

    kpq_pkg::timer_t press_timer_reg, press_timer_next;
    kpq_pkg::timer_t repeat_timer_reg, repeat_timer_next;
    kpq_pkg::timer_t click_clock_reg, click_clock_next;
    kpq_pkg::timer_t first_stamp_reg, first_stamp_next;
    kpq_pkg::timer_t second_stamp_reg, second_stamp_next;
    logic down_reg, down_next;
    logic long_flag_reg, long_flag_next;
    logic phase_reg, phase_next;

    logic out_valid_reg;
    kpq_pkg::events_t out_reg, ev_next;

    logic accept;
    logic cfg_write;
    kpq_pkg::reg_index_t reg_index;
    kpq_pkg::interval_t interval;
    logic pressed;
    kpq_pkg::timer_t press_sum, repeat_sum, stamp_a, stamp_b;
    logic [kpq_pkg::TIMER_BITS:0] stamp_diff;
    kpq_pkg::timer_t stamp_gap;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_index = kpq_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_en_reg  <= 1'b0;
            up_en_reg    <= 1'b0;
            dc_en_reg    <= 1'b0;
            rep_en_reg   <= 1'b0;
            debounce_reg <= kpq_pkg::DEBOUNCE_RESET;
            long_reg     <= kpq_pkg::LONG_RESET;
            period_reg   <= kpq_pkg::PERIOD_RESET;
            window_reg   <= kpq_pkg::WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                kpq_pkg::REG_DOWN_EN:  down_en_reg  <= pwdata[0];
                kpq_pkg::REG_UP_EN:    up_en_reg    <= pwdata[0];
                kpq_pkg::REG_DC_EN:    dc_en_reg    <= pwdata[0];
                kpq_pkg::REG_REP_EN:   rep_en_reg   <= pwdata[0];
                kpq_pkg::REG_DEBOUNCE: debounce_reg <= pwdata[kpq_pkg::CFG_BITS-1:0];
                kpq_pkg::REG_LONG:     long_reg     <= pwdata[kpq_pkg::CFG_BITS-1:0];
                kpq_pkg::REG_PERIOD:   period_reg   <= pwdata[kpq_pkg::CFG_BITS-1:0];
                kpq_pkg::REG_WINDOW:   window_reg   <= pwdata[kpq_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            kpq_pkg::REG_DOWN_EN:  prdata = kpq_pkg::DATA_BITS'(down_en_reg);
            kpq_pkg::REG_UP_EN:    prdata = kpq_pkg::DATA_BITS'(up_en_reg);
            kpq_pkg::REG_DC_EN:    prdata = kpq_pkg::DATA_BITS'(dc_en_reg);
            kpq_pkg::REG_REP_EN:   prdata = kpq_pkg::DATA_BITS'(rep_en_reg);
            kpq_pkg::REG_DEBOUNCE: prdata = kpq_pkg::DATA_BITS'(debounce_reg);
            kpq_pkg::REG_LONG:     prdata = kpq_pkg::DATA_BITS'(long_reg);
            kpq_pkg::REG_PERIOD:   prdata = kpq_pkg::DATA_BITS'(period_reg);
            kpq_pkg::REG_WINDOW:   prdata = kpq_pkg::DATA_BITS'(window_reg);
            default:               prdata = '0;
        endcase
    end

    // Stream handshake
    assign s_tready = ~out_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign interval = s_tdata[kpq_pkg::INTERVAL_BITS-1:0];
    assign pressed  = s_tdata[kpq_pkg::INTERVAL_BITS];

    always_comb
    begin
        ev_next           = '0;
        press_timer_next  = press_timer_reg;
        repeat_timer_next = repeat_timer_reg;
        down_next         = down_reg;
        long_flag_next    = long_flag_reg;
        phase_next        = phase_reg;
        first_stamp_next  = first_stamp_reg;
        second_stamp_next = second_stamp_reg;
        click_clock_next  = click_clock_reg;
        stamp_a           = first_stamp_reg;
        stamp_b           = second_stamp_reg;
        stamp_diff        = '0;
        stamp_gap         = '0;
        press_sum         = kpq_pkg::sat_add(press_timer_reg, interval);
        repeat_sum        = '0;

        if (dc_en_reg)
            click_clock_next = click_clock_reg + kpq_pkg::TIMER_BITS'(interval);

        if (pressed)
        begin
            press_timer_next = press_sum;
            if (kpq_pkg::CMP_BITS'(press_sum) >= kpq_pkg::CMP_BITS'(debounce_reg) && !down_reg)
            begin
                down_next              = 1'b1;
                ev_next.key_down_event = down_en_reg;
                ev_next.beep_press     = 1'b1;
                if (dc_en_reg)
                begin
                    phase_next = ~phase_reg;
                    if (phase_next)
                        stamp_a = click_clock_next;
                    else
                        stamp_b = click_clock_next;
                    first_stamp_next  = stamp_a;
                    second_stamp_next = stamp_b;
                    // Absolute gap between the two stamps; equal stamps never match.
                    stamp_diff = {1'b0, stamp_b} - {1'b0, stamp_a};
                    stamp_gap  = stamp_diff[kpq_pkg::TIMER_BITS] ?
                                 stamp_a - stamp_b : stamp_diff[kpq_pkg::TIMER_BITS-1:0];
                    if (stamp_gap != '0 &&
                        kpq_pkg::CMP_BITS'(stamp_gap) < kpq_pkg::CMP_BITS'(window_reg))
                    begin
                        ev_next.double_click_event = 1'b1;
                        click_clock_next           = '0;
                    end
                end
            end
            if (kpq_pkg::CMP_BITS'(press_sum) >= kpq_pkg::CMP_BITS'(long_reg))
            begin
                long_flag_next   = 1'b1;
                click_clock_next = '0;
            end
            if (long_flag_next && rep_en_reg)
            begin
                repeat_sum        = kpq_pkg::sat_add(repeat_timer_reg, interval);
                repeat_timer_next = repeat_sum;
                if (kpq_pkg::CMP_BITS'(repeat_sum) >= kpq_pkg::CMP_BITS'(period_reg))
                begin
                    ev_next.repeat_event = 1'b1;
                    ev_next.beep_repeat  = 1'b1;
                    repeat_timer_next    = '0;
                end
            end
        end
        else
        begin
            ev_next.key_up_event = down_reg & up_en_reg;
            press_timer_next     = '0;
            repeat_timer_next    = '0;
            down_next            = 1'b0;
            long_flag_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_timer_reg  <= '0;
            repeat_timer_reg <= '0;
            click_clock_reg  <= '0;
            first_stamp_reg  <= '0;
            second_stamp_reg <= '0;
            down_reg         <= 1'b0;
            long_flag_reg    <= 1'b0;
            phase_reg        <= 1'b0;
        end
        else if (accept)
        begin
            press_timer_reg  <= press_timer_next;
            repeat_timer_reg <= repeat_timer_next;
            click_clock_reg  <= click_clock_next;
            first_stamp_reg  <= first_stamp_next;
            second_stamp_reg <= second_stamp_next;
            down_reg         <= down_next;
            long_flag_reg    <= long_flag_next;
            phase_reg        <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= ev_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = kpq_pkg::OUT_WORD_BITS'(out_reg);

endmodule

>>> rtl/core/kpq_checker.sv
// Port-level checks for key_press_qualifier_unit, attached by the bind below.
// Depends on the top level's port list only.
module kpq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // The input side stalls only while a result waits to be taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

    // Every accepted word yields a result word in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted word gave no result");

    // A repeat event always carries its beep request.
    a_repeat_beep: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == m_tdata[5]))
        else $error("repeat event and repeat beep disagree");

    // Down and double-click events only come with a press beep; up and down never together.
    a_press_beep: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[0] || m_tdata[2])) |-> (m_tdata[4] && !m_tdata[1]))
        else $error("down edge without press beep or with up event");

endmodule

bind key_press_qualifier_unit kpq_checker u_kpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
